### rtl/dbw_pkg.sv
// Shared widths, reset values, register indexes and types for the
// disparity backward warp row block. Depends on nothing.
`default_nettype none

package dbw_pkg;

    // Row buffer geometry. The column field is 10 bits wide, so the row
    // buffer holds one entry for every column code.
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Payload field widths.
    localparam int COL_W  = 10;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int DISP_W = 8;

    // Configuration registers.
    localparam int VF_W       = 17;
    localparam int AW_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [VF_W-1:0] VF_RESET = VF_W'(32768);
    localparam logic [AW_W-1:0] AW_RESET = AW_W'(1024);
    localparam logic [AW_W-1:0] AW_MAX   = AW_W'(MAX_WIDTH);

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_FRACTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b1;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WARP = 1'b1;

    // Offset arithmetic: negated disparity (9 bits) times the view fraction
    // (18 bits as signed) gives a 27 bit product in Q.16.
    localparam int FRAC_BITS = 16;
    localparam int NDISP_W   = DISP_W + 1;
    localparam int PROD_W    = NDISP_W + VF_W + 1;
    localparam int OFS_W     = PROD_W - FRAC_BITS;
    localparam int SRC_W     = OFS_W + 1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

`default_nettype wire

### rtl/dbw_in_if.sv
// Input channel of the warp block: one load or warp item per handshake.
// Depends on dbw_pkg for the field widths.
`default_nettype none

interface dbw_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [dbw_pkg::COL_W-1:0]        column;
    logic [dbw_pkg::CHAN_W-1:0]       src_red;
    logic [dbw_pkg::CHAN_W-1:0]       src_green;
    logic [dbw_pkg::CHAN_W-1:0]       src_blue;
    logic signed [dbw_pkg::DISP_W-1:0] disparity;

    modport source (
        output valid, command, column, src_red, src_green, src_blue, disparity,
        input  ready
    );
    modport sink (
        input  valid, command, column, src_red, src_green, src_blue, disparity,
        output ready
    );
endinterface

`default_nettype wire

### rtl/dbw_out_if.sv
// Output channel of the warp block: one warped pixel item per handshake.
// Depends on dbw_pkg for the field widths.
`default_nettype none

interface dbw_out_if;
    logic                       valid;
    logic                       ready;
    logic [dbw_pkg::CHAN_W-1:0] out_red;
    logic [dbw_pkg::CHAN_W-1:0] out_green;
    logic [dbw_pkg::CHAN_W-1:0] out_blue;
    logic                       hit;
    logic [dbw_pkg::COL_W-1:0]  out_column;

    modport source (
        output valid, out_red, out_green, out_blue, hit, out_column,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, hit, out_column,
        output ready
    );
endinterface

`default_nettype wire

### rtl/dbw_row_mem.sv
// Row pixel buffer: one write port and one read port, registered read data.
// Depends on dbw_pkg for geometry and the port structs.
`default_nettype none

module dbw_row_mem (
    input  wire logic                       i_clk,
    input  wire dbw_pkg::t_mem_wr           i_wr,
    input  wire dbw_pkg::t_mem_rd           i_rd,
    output logic [dbw_pkg::PIX_W-1:0]       o_rd_data
);

    logic [dbw_pkg::PIX_W-1:0] r_mem [dbw_pkg::MAX_WIDTH];
    logic [dbw_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // The read register holds its value while the read is not enabled, so
    // a stalled result keeps its pixel.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/disparity_backward_warp_row.sv
// A warp item's result is offered from the output register, after the item has
// passed the stage one register; the row memory's read register holds its pixel.
// Throughput: one item per cycle, load or warp, while the output is not stalled;
// the row memory's single read and single write port each serve one item per cycle.
// Loads produce no result. Reset (synchronous, active low) empties the pipeline
// and restores view_fraction to 32768 and active_width to 1024; the row buffer
// is not cleared and must be loaded before it is read.
`default_nettype none

module disparity_backward_warp_row (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dbw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dbw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dbw_in_if.sink                                i_in,
    dbw_out_if.source                             o_out
);

    // Configuration registers.
    logic [dbw_pkg::VF_W-1:0] r_view_fraction;
    logic [dbw_pkg::AW_W-1:0] r_active_width;

    // Stage one holds the accepted item and the registered product.
    logic                             r1_valid;
    logic                             r1_cmd;
    logic [dbw_pkg::COL_W-1:0]        r1_col;
    logic [dbw_pkg::PIX_W-1:0]        r1_pix;
    logic signed [dbw_pkg::PROD_W-1:0] r1_prod;

    // Stage two is the output register; the pixel itself sits in the row
    // memory's read register.
    logic                      r2_valid;
    logic                      r2_hit;
    logic [dbw_pkg::COL_W-1:0] r2_col;

    logic                               w_adv;
    logic signed [dbw_pkg::NDISP_W-1:0] w_neg_disp;
    logic signed [dbw_pkg::VF_W:0]      w_vf_s;
    logic signed [dbw_pkg::PROD_W-1:0]  w_prod;
    logic [dbw_pkg::AW_W-1:0]           w_aw;
    logic signed [dbw_pkg::SRC_W-1:0]   w_src;
    logic                               w_hit;
    logic [dbw_pkg::PIX_W-1:0]          w_rd_data;
    dbw_pkg::t_mem_wr                   w_wr;
    dbw_pkg::t_mem_rd                   w_rd;

    // The whole pipeline moves when the output register is empty or being
    // taken. A result waiting at the output therefore does not keep the
    // input from taking an item in the same cycle it is consumed.
    assign w_adv      = !r2_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_fraction <= dbw_pkg::VF_RESET;
            r_active_width  <= dbw_pkg::AW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dbw_pkg::CFG_VIEW_FRACTION: begin
                    r_view_fraction <= i_cfg_data[dbw_pkg::VF_W-1:0];
                end
                dbw_pkg::CFG_ACTIVE_WIDTH: begin
                    r_active_width <= i_cfg_data[dbw_pkg::AW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage zero: the offset product -disparity * view_fraction. The negated
    // disparity needs nine bits because -(-128) is 128.
    assign w_neg_disp = dbw_pkg::NDISP_W'(0)
                      - $signed({i_in.disparity[dbw_pkg::DISP_W-1], i_in.disparity});
    assign w_vf_s     = $signed({1'b0, r_view_fraction});
    assign w_prod     = dbw_pkg::PROD_W'(w_neg_disp) * dbw_pkg::PROD_W'(w_vf_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_cmd  <= i_in.command;
            r1_col  <= i_in.column;
            r1_pix  <= {i_in.src_red, i_in.src_green, i_in.src_blue};
            r1_prod <= w_prod;
        end
    end

    // Stage one: the arithmetic shift of the Q.16 product is the floor, for
    // negative products as well. The source column and the range checks
    // follow, and the row memory is read or written here. Loads and reads
    // both happen in this stage, so program order is kept without forwarding.
    assign w_aw  = (r_active_width > dbw_pkg::AW_MAX) ? dbw_pkg::AW_MAX : r_active_width;
    assign w_src = $signed({{(dbw_pkg::SRC_W - dbw_pkg::COL_W){1'b0}}, r1_col})
                 + $signed({r1_prod[dbw_pkg::PROD_W-1],
                            r1_prod[dbw_pkg::PROD_W-1:dbw_pkg::FRAC_BITS]});
    assign w_hit = ({1'b0, r1_col} < w_aw)
                && !w_src[dbw_pkg::SRC_W-1]
                && (w_src < $signed({{(dbw_pkg::SRC_W - dbw_pkg::AW_W){1'b0}}, w_aw}));

    always_comb begin
        w_wr.en   = w_adv && r1_valid && (r1_cmd == dbw_pkg::CMD_LOAD);
        w_wr.addr = r1_col[dbw_pkg::ADDR_W-1:0];
        w_wr.data = r1_pix;
        w_rd.en   = w_adv;
        w_rd.addr = w_src[dbw_pkg::ADDR_W-1:0];
    end

    dbw_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // Stage two: only warp items become results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid && (r1_cmd == dbw_pkg::CMD_WARP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_hit <= w_hit;
            r2_col <= r1_col;
        end
    end

    // A miss shows a black pixel.
    assign o_out.valid      = r2_valid;
    assign o_out.hit        = r2_hit;
    assign o_out.out_column = r2_col;
    assign o_out.out_red    = r2_hit ? w_rd_data[3*dbw_pkg::CHAN_W-1:2*dbw_pkg::CHAN_W]
                                     : '0;
    assign o_out.out_green  = r2_hit ? w_rd_data[2*dbw_pkg::CHAN_W-1:dbw_pkg::CHAN_W]
                                     : '0;
    assign o_out.out_blue   = r2_hit ? w_rd_data[dbw_pkg::CHAN_W-1:0] : '0;

endmodule

`default_nettype wire

### rtl/dbw_checker.sv
// Port-level checks for the disparity backward warp row block, bound to
// the top level. Depends on the top level's port names only.
`default_nettype none

module dbw_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_hit
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // A result on offer that is not taken stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hit)))
        else $error("result withdrawn or changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // With no result waiting, the input side is never held off.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

    // Nothing accepted and nothing on offer means no new result appears.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_acc && !i_out_valid) |=> ##1 (!i_out_valid || $past(i_out_valid)))
        else $error("result appeared without an accepted item");

endmodule

bind disparity_backward_warp_row dbw_checker u_dbw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit)
);

`default_nettype wire
